// File: rtl/core/swcm_pkg.sv
// Shared types and constants for the six-way covariance matrix block.
// No dependencies; used by swcm_mac and the top level.
`timescale 1ns / 1ps
`default_nettype none

package swcm_pkg;

    localparam int NVAR            = 6;
    localparam int LANE_W          = 24;
    localparam int DEV_W           = LANE_W + 1;
    localparam int PROD_W          = 2 * DEV_W;
    localparam int COV_W           = 49;
    localparam int IDX_W           = 3;
    localparam int MAX_SAMPLES_DEF = 1024;

    // Control between the sequencer and the multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/swcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swcm_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swcm_div.sv
// Shared bit-serial signed divider: signed dividend by unsigned divisor,
// quotient truncated toward zero. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module swcm_div #(
    parameter int NUM_W = 61,
    parameter int DEN_W = 11
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] dividend,
    input  wire logic        [DEN_W-1:0] divisor,
    output logic                         done,
    output logic signed      [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic             neg_reg,   neg_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [NUM_W-1:0] quo_reg,   quo_next;
    logic [DEN_W-1:0] den_reg,   den_next;
    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        if (start && !busy_reg) begin
            busy_next = 1'b1;
            neg_next  = dividend[NUM_W-1];
            quo_next  = dividend[NUM_W-1] ? (~dividend + 1'b1) : dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W);
        end else if (busy_reg) begin
            // one quotient bit per cycle, restoring form
            if (rem_shift >= {1'b0, den_reg}) begin
                rem_next = rem_diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

`default_nettype wire

// File: rtl/core/swcm_mac.sv
// Deviation, multiply and accumulate pipeline for one matrix entry.
// Depends on swcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swcm_mac #(
    parameter int ACC_W = 61
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire swcm_pkg::mac_ctrl_t                          ctrl,
    input  wire logic [swcm_pkg::NVAR*swcm_pkg::LANE_W-1:0]   row_data,
    input  wire logic [swcm_pkg::IDX_W-1:0]                   sel_a,
    input  wire logic [swcm_pkg::IDX_W-1:0]                   sel_b,
    input  wire logic signed [swcm_pkg::LANE_W-1:0]           mean_a,
    input  wire logic signed [swcm_pkg::LANE_W-1:0]           mean_b,
    output logic                                              busy,
    output logic signed [ACC_W-1:0]                           acc
);

    logic signed [swcm_pkg::LANE_W-1:0] lane_a, lane_b;
    logic signed [swcm_pkg::DEV_W-1:0]  dev_a_reg, dev_b_reg;
    logic signed [swcm_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]            acc_reg;
    logic                               v1_reg, v2_reg;

    always_comb begin
        lane_a = '0;
        lane_b = '0;
        for (int l = 0; l < swcm_pkg::NVAR; l++) begin
            if (sel_a == swcm_pkg::IDX_W'(l)) begin
                lane_a = row_data[l*swcm_pkg::LANE_W +: swcm_pkg::LANE_W];
            end
            if (sel_b == swcm_pkg::IDX_W'(l)) begin
                lane_b = row_data[l*swcm_pkg::LANE_W +: swcm_pkg::LANE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.valid;
            v2_reg <= v1_reg;
        end
        dev_a_reg <= swcm_pkg::DEV_W'(lane_a) - swcm_pkg::DEV_W'(mean_a);
        dev_b_reg <= swcm_pkg::DEV_W'(lane_b) - swcm_pkg::DEV_W'(mean_b);
        prod_reg  <= dev_a_reg * dev_b_reg;
        if (ctrl.clear) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = v1_reg | v2_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

// File: rtl/core/six_way_covariance_matrix.sv
// Top level of the six-way population covariance matrix block.
// Depends on swcm_pkg, swcm_ram, swcm_div and swcm_mac.
`timescale 1ns / 1ps
`default_nettype none

// Samples of six signed Q11.12 values stream in one per cycle and are stored
// in a row-per-sample RAM while six running sums are kept. The sample flagged
// with s_tlast closes the set: each mean (sum / count, truncated) comes out of
// a shared bit-serial divider, then for each of the 36 matrix entries one pass
// over the stored samples feeds a single multiply-accumulate pipeline, and the
// shared divider turns the sum into the covariance. Entries leave in row-major
// order as signed Q24.24, saturated, with m_tlast on the last one and m_tuser
// set when samples past MAX_SAMPLES were dropped. s_tready is low from the
// closing sample until the last entry is taken. The divider works on
// P = 50 + clog2(MAX_SAMPLES+1) dividend bits, one quotient bit per cycle,
// and the RAM read port feeds the MAC one stored sample per cycle.
module six_way_covariance_matrix #(
    parameter int MAX_SAMPLES = swcm_pkg::MAX_SAMPLES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rise[23:0], roll[47:24], shift[71:48], slide[95:72], tilt[119:96], twist[143:120]
    input  wire logic [143:0] s_tdata,
    input  wire logic         s_tlast,    // final_sample
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // row[2:0], column[5:3], covariance[54:6], zero pad[55]
    output logic [55:0]       m_tdata,
    output logic              m_tuser,    // overflowed
    output logic              m_tlast     // end_of_matrix
);

    localparam int NVAR   = swcm_pkg::NVAR;
    localparam int LANE_W = swcm_pkg::LANE_W;
    localparam int IDX_W  = swcm_pkg::IDX_W;
    localparam int COV_W  = swcm_pkg::COV_W;
    localparam int ROW_W  = NVAR * LANE_W;
    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int AW     = $clog2(MAX_SAMPLES);
    localparam int SW     = LANE_W + CW;
    localparam int PW     = swcm_pkg::PROD_W + CW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MEAN_START, ST_MEAN_WAIT, ST_SETUP_A, ST_SETUP_B,
        ST_RUN, ST_DRAIN, ST_DIV_START, ST_DIV_WAIT, ST_EMIT
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic                      dropped_reg;
    logic signed [SW-1:0]      sum_reg  [NVAR];
    logic signed [LANE_W-1:0]  mean_reg [NVAR];
    logic [IDX_W-1:0]          var_reg, a_reg, b_reg;
    logic [CW-1:0]             idx_reg;
    logic signed [LANE_W-1:0]  mean_a_reg, mean_b_reg;
    logic                      rvalid_reg;
    logic                      m_tvalid_reg;
    logic [55:0]               m_tdata_reg;
    logic                      m_tuser_reg, m_tlast_reg;

    logic                      accept, store_ok, last_pair;
    logic                      ram_re;
    logic [ROW_W-1:0]          ram_rdata;
    logic                      div_start, div_done;
    logic signed [PW-1:0]      div_num, div_q;
    logic                      mac_busy;
    logic signed [PW-1:0]      mac_acc;
    swcm_pkg::mac_ctrl_t       mac_ctrl;
    logic signed [COV_W-1:0]   cov_sat;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign store_ok  = (count_reg != CW'(MAX_SAMPLES));
    assign last_pair = (a_reg == IDX_W'(NVAR - 1)) && (b_reg == IDX_W'(NVAR - 1));
    assign ram_re    = (state_reg == ST_RUN);
    assign div_start = (state_reg == ST_MEAN_START) || (state_reg == ST_DIV_START);
    assign div_num   = (state_reg == ST_MEAN_START) ? PW'(sum_reg[var_reg]) : mac_acc;

    assign mac_ctrl.clear = (state_reg == ST_SETUP_A);
    assign mac_ctrl.valid = rvalid_reg;

    // clamp the quotient to the 49-bit signed output range
    always_comb begin
        if (!div_q[PW-1] && (|div_q[PW-2:COV_W-1])) begin
            cov_sat = {1'b0, {(COV_W-1){1'b1}}};
        end else if (div_q[PW-1] && !(&div_q[PW-2:COV_W-1])) begin
            cov_sat = {1'b1, {(COV_W-1){1'b0}}};
        end else begin
            cov_sat = div_q[COV_W-1:0];
        end
    end

    swcm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .aclk  (aclk),
        .we    (accept && store_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    swcm_div #(
        .NUM_W (PW),
        .DEN_W (CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    swcm_mac #(
        .ACC_W (PW)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .row_data (ram_rdata),
        .sel_a    (a_reg),
        .sel_b    (b_reg),
        .mean_a   (mean_a_reg),
        .mean_b   (mean_b_reg),
        .busy     (mac_busy),
        .acc      (mac_acc)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            dropped_reg  <= 1'b0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            var_reg      <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
            idx_reg      <= '0;
            for (int l = 0; l < NVAR; l++) begin
                sum_reg[l] <= '0;
            end
        end else begin
            rvalid_reg <= ram_re;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        // store and sum, or drop when the store is full
                        if (store_ok) begin
                            count_reg <= count_reg + 1'b1;
                            for (int l = 0; l < NVAR; l++) begin
                                sum_reg[l] <= sum_reg[l]
                                    + SW'($signed(s_tdata[l*LANE_W +: LANE_W]));
                            end
                        end else begin
                            dropped_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            var_reg   <= '0;
                            state_reg <= ST_MEAN_START;
                        end
                    end
                end
                ST_MEAN_START: begin
                    state_reg <= ST_MEAN_WAIT;
                end
                ST_MEAN_WAIT: begin
                    if (div_done) begin
                        mean_reg[var_reg] <= div_q[LANE_W-1:0];
                        if (var_reg == IDX_W'(NVAR - 1)) begin
                            a_reg     <= '0;
                            b_reg     <= '0;
                            state_reg <= ST_SETUP_A;
                        end else begin
                            var_reg   <= var_reg + 1'b1;
                            state_reg <= ST_MEAN_START;
                        end
                    end
                end
                ST_SETUP_A: begin
                    mean_a_reg <= mean_reg[a_reg];
                    state_reg  <= ST_SETUP_B;
                end
                ST_SETUP_B: begin
                    mean_b_reg <= mean_reg[b_reg];
                    idx_reg    <= '0;
                    state_reg  <= ST_RUN;
                end
                ST_RUN: begin
                    // one stored sample per cycle into the MAC pipeline
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == count_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!rvalid_reg && !mac_busy) begin
                        state_reg <= ST_DIV_START;
                    end
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        m_tdata_reg  <= {1'b0, cov_sat, b_reg, a_reg};
                        m_tuser_reg  <= dropped_reg;
                        m_tlast_reg  <= last_pair;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // hold the entry until the request is taken
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        if (last_pair) begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            for (int l = 0; l < NVAR; l++) begin
                                sum_reg[l] <= '0;
                            end
                            state_reg <= ST_IDLE;
                        end else begin
                            if (b_reg == IDX_W'(NVAR - 1)) begin
                                b_reg <= '0;
                                a_reg <= a_reg + 1'b1;
                            end else begin
                                b_reg <= b_reg + 1'b1;
                            end
                            state_reg <= ST_SETUP_A;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for six_way_covariance_matrix: streams sample sets,
// predicts each 6x6 covariance matrix in the bench and compares every entry.
// Depends on swcm_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int NVAR      = swcm_pkg::NVAR;
    localparam int COV_W     = swcm_pkg::COV_W;
    localparam int CAP       = 1024;
    localparam longint LIMIT = 3_000_000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    typedef struct packed {
        logic [2:0]        row;
        logic [2:0]        column;
        logic [COV_W-1:0]  covariance;
        logic              overflowed;
        logic              end_of_matrix;
    } entry_t;

    entry_t pending_entries[$];

    // Predictor state for the current set
    logic signed [23:0] stored[CAP][NVAR];
    longint             lane_sum[NVAR];
    int                 stored_count;
    bit                 dropped;

    int     errors;
    longint cycles;
    bit     quiet_rx;
    bit     quiet_tx;

    six_way_covariance_matrix #(.MAX_SAMPLES(CAP)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Absorb one sample into the predictor; on the closing sample, queue 36 entries.
    task automatic absorb_sample(input logic [143:0] lanes, input bit closing);
        longint mean[NVAR];
        longint dev[NVAR];
        longint acc[NVAR*NVAR];
        longint c;
        entry_t e;
        if (stored_count < CAP) begin
            for (int a = 0; a < NVAR; a++) begin
                stored[stored_count][a] = lanes[a*24 +: 24];
                lane_sum[a] += longint'(signed'(lanes[a*24 +: 24]));
            end
            stored_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!closing) return;
        for (int a = 0; a < NVAR; a++)
            mean[a] = stored_count ? lane_sum[a] / stored_count : 0;
        foreach (acc[k]) acc[k] = 0;
        for (int i = 0; i < stored_count; i++) begin
            for (int a = 0; a < NVAR; a++) dev[a] = longint'(stored[i][a]) - mean[a];
            for (int a = 0; a < NVAR; a++)
                for (int b = 0; b < NVAR; b++) acc[a*NVAR+b] += dev[a] * dev[b];
        end
        for (int k = 0; k < NVAR*NVAR; k++) begin
            c = stored_count ? acc[k] / stored_count : 0;
            if (c > 64'sd281474976710655) c = 64'sd281474976710655;
            if (c < -64'sd281474976710656) c = -64'sd281474976710656;
            e.row = 3'(k / NVAR);
            e.column = 3'(k % NVAR);
            e.covariance = c[COV_W-1:0];
            e.overflowed = dropped;
            e.end_of_matrix = (k == NVAR*NVAR - 1);
            pending_entries = {pending_entries, e};
        end
        foreach (lane_sum[a]) lane_sum[a] = 0;
        stored_count = 0;
        dropped = 1'b0;
    endtask

    // Present one request and hold it until the handshake; drop valid only while idling.
    task automatic send_sample(input logic [143:0] lanes, input bit closing);
        if (!quiet_tx && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (!quiet_tx && $urandom_range(99) < 38);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lanes;
        s_tlast  <= closing;
        do @(posedge aclk); while (!s_tready);
        absorb_sample(lanes, closing);
    endtask

    function automatic logic [143:0] random_lanes(input int style);
        logic [143:0] v;
        for (int a = 0; a < NVAR; a++) begin
            case (style)
                0: v[a*24 +: 24] = 24'($urandom);
                1: v[a*24 +: 24] = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
                default: v[a*24 +: 24] = 24'($signed($urandom_range(4000)) - 2000);
            endcase
        end
        return v;
    endfunction

    // Directed table: extremes, constants, single-sample sets, opposite corners.
    typedef struct {
        logic [143:0] lanes;
        bit           closing;
    } stim_row_t;

    stim_row_t directed_rows[10] = '{
        '{ {6{24'h000000}}, 1'b1 },                // one sample: all zeros
        '{ {6{24'h7FFFFF}}, 1'b1 },                // one sample: max
        '{ {6{24'h800000}}, 1'b0 },                // min then max: widest spread
        '{ {6{24'h7FFFFF}}, 1'b1 },
        '{ {3{24'h7FFFFF, 24'h800000}}, 1'b0 },    // anti-correlated lanes
        '{ {3{24'h800000, 24'h7FFFFF}}, 1'b0 },
        '{ {6{24'hFFFFFF}}, 1'b1 },                // truncated means toward zero
        '{ {6{24'h555555}}, 1'b0 },
        '{ {6{24'hAAAAAA}}, 1'b0 },
        '{ {6{24'h000001}}, 1'b1 }
    };

    // Receiver: random stalls, checks each accepted entry against the oldest prediction.
    always @(posedge aclk) begin
        entry_t got;
        entry_t want;
        m_tready <= aresetn && (quiet_rx || $urandom_range(99) >= 38);
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[5:3], m_tdata[54:6], m_tuser, m_tlast};
            if (pending_entries.size() == 0) begin
                $display("%0t: unexpected entry %h", $realtime, got);
                errors++;
            end else begin
                want = pending_entries.pop_front();
                if (got !== want) begin
                    $display("%0t: entry mismatch expected r%0d c%0d cov %h ov %b last %b",
                             $realtime, want.row, want.column, want.covariance,
                             want.overflowed, want.end_of_matrix);
                    $display("%0t:                  actual r%0d c%0d cov %h ov %b last %b",
                             $realtime, got.row, got.column, got.covariance,
                             got.overflowed, got.end_of_matrix);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run on a hung handshake.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int n;
        int set_len;
        errors = 0; cycles = 0; stored_count = 0; dropped = 0;
        quiet_rx = 0; quiet_tx = 0;
        foreach (lane_sum[a]) lane_sum[a] = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) send_sample(directed_rows[i].lanes, directed_rows[i].closing);

        // Overflow set: fill the store, drop a few, and drop the closing sample too.
        for (int i = 0; i < CAP + 3; i++) send_sample(random_lanes(2), 1'b0);
        send_sample(random_lanes(0), 1'b1);

        // Random sets, mostly short; one stretch without any idling.
        n = 0;
        while (n < 360) begin
            quiet_tx = (n >= 150 && n < 210);
            quiet_rx = quiet_tx;
            set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            for (int j = 0; j < set_len; j++)
                send_sample(random_lanes($urandom_range(2)), j == set_len - 1);
            n += set_len;
        end
        s_tvalid <= 1'b0;
        quiet_tx = 0; quiet_rx = 0;

        wait (pending_entries.size() == 0);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending_entries.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: six_way_covariance_matrix.f
rtl/core/swcm_pkg.sv
rtl/core/swcm_ram.sv
rtl/core/swcm_div.sv
rtl/core/swcm_mac.sv
rtl/core/six_way_covariance_matrix.sv
tb/tb_top.sv
